FILE: rtl/core/qrs_pkg.sv
`default_nettype none

package qrs_pkg;

    typedef enum logic [1:0] {
        ST_TWO_ROOTS = 2'd0,
        ST_ONE_ROOT  = 2'd1,
        ST_NO_ROOTS  = 2'd2,
        ST_INVALID   = 2'd3
    } t_status;

    // coefficient classification made by the front end
    typedef struct packed {
        logic a_zero;
        logic b_zero;
    } t_cls;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

endpackage

`default_nettype wire

FILE: rtl/core/qrs_ifs.sv
`default_nettype none

interface qrs_req_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] coef_a;
    logic signed [W-1:0] coef_b;
    logic signed [W-1:0] coef_c;

    modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrs_rsp_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic signed [W-1:0] root_plus;
    logic signed [W-1:0] root_minus;
    logic                saturated;

    modport source (output valid, output status, output root_plus, output root_minus,
                    output saturated, input ready);
    modport sink   (input valid, input status, input root_plus, input root_minus,
                    input saturated, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/quadratic_root_solver_core.sv
// result path: front stages, queue, discriminant register, square root pipeline,
// divider pipeline and output register; throughput: one transaction per cycle while
// o_rsp.ready does not stall the back end; a four-entry queue decouples front and back
// reset: synchronous active-low i_rst_n clears all valid flags and the queue pointers
`default_nettype none

module quadratic_root_solver_core
    import qrs_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    qrs_req_if.sink   i_req,
    qrs_rsp_if.source o_rsp
);

    localparam int FW = 7*WORD_BITS + 5;

    logic          w_push, w_pop, w_full, w_empty;
    logic [FW-1:0] w_fdata, w_bdata;

    qrs_front #(.W(WORD_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_data  (w_fdata)
    );

    qrs_fifo #(.DW(FW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_fdata),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_bdata)
    );

    qrs_back #(.W(WORD_BITS), .F(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .i_data  (w_bdata),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

FILE: rtl/core/qrs_front.sv
`default_nettype none

module qrs_front
    import qrs_pkg::*;
#(
    parameter int W = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    qrs_req_if.sink            i_req,
    input  wire logic          i_full,
    output logic               o_push,
    output logic [7*W+4:0]     o_data
);

    logic         w_na, w_nb, w_nc;
    logic [W-1:0] w_ma, w_mb, w_mc;
    logic         w_adv;

    // stage 1: sign and magnitude
    logic         r_f1_v;
    logic         r_na, r_nb, r_nc;
    logic [W-1:0] r_ma, r_mb, r_mc;

    // stage 2: products and zero classification
    logic          r_f2_v;
    t_cls          r_cls;
    logic          r_na2, r_nb2, r_nc2;
    logic [W-1:0]  r_ma2, r_mb2, r_mc2;
    logic [2*W-1:0] r_b2, r_ac;

    assign w_na = i_req.coef_a[W-1];
    assign w_nb = i_req.coef_b[W-1];
    assign w_nc = i_req.coef_c[W-1];
    assign w_ma = w_na ? (~i_req.coef_a + W'(1)) : i_req.coef_a;
    assign w_mb = w_nb ? (~i_req.coef_b + W'(1)) : i_req.coef_b;
    assign w_mc = w_nc ? (~i_req.coef_c + W'(1)) : i_req.coef_c;

    assign w_adv       = !r_f2_v || !i_full;
    assign i_req.ready = !r_f1_v || w_adv;
    assign o_push      = r_f2_v && !i_full;
    assign o_data      = {r_cls, r_na2, r_nb2, r_nc2, r_ma2, r_mb2, r_mc2, r_b2, r_ac};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else if (i_req.ready) begin
            r_f1_v <= i_req.valid;
        end
        if (i_req.ready) begin
            r_na <= w_na;
            r_nb <= w_nb;
            r_nc <= w_nc;
            r_ma <= w_ma;
            r_mb <= w_mb;
            r_mc <= w_mc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_v <= 1'b0;
        end else if (w_adv) begin
            r_f2_v <= r_f1_v;
        end
        if (w_adv) begin
            r_cls.a_zero <= (r_ma == '0);
            r_cls.b_zero <= (r_mb == '0);
            r_na2 <= r_na;
            r_nb2 <= r_nb;
            r_nc2 <= r_nc;
            r_ma2 <= r_ma;
            r_mb2 <= r_mb;
            r_mc2 <= r_mc;
            r_b2  <= {{W{1'b0}}, r_mb} * {{W{1'b0}}, r_mb};
            r_ac  <= {{W{1'b0}}, r_ma} * {{W{1'b0}}, r_mc};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/qrs_fifo.sv
`default_nettype none

module qrs_fifo
    import qrs_pkg::*;
#(
    parameter int DW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [DW-1:0] i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output logic [DW-1:0]      o_data
);

    logic [DW-1:0]    r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + FIFO_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (FIFO_AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (FIFO_AW+1)'(1);
            end
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/qrs_isqrt.sv
`default_nettype none

module qrs_isqrt #(
    parameter int RB = 33,
    parameter int SW = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [2*RB-1:0] i_rad,
    input  wire logic [SW-1:0]   i_side,
    output logic                 o_valid,
    output logic [RB-1:0]        o_root,
    output logic [SW-1:0]        o_side
);

    logic [RB+1:0]   a_rem  [RB+1];
    logic [RB-1:0]   a_root [RB+1];
    logic [2*RB-1:0] a_rad  [RB+1];
    logic [SW-1:0]   a_side [RB+1];
    logic            a_vld  [RB+1];

    assign a_rem[0]  = '0;
    assign a_root[0] = '0;
    assign a_rad[0]  = i_rad;
    assign a_side[0] = i_side;
    assign a_vld[0]  = i_valid;

    // one result bit per stage, two radicand bits consumed per stage
    for (genvar k = 0; k < RB; k++) begin : g_stage
        logic [RB+1:0]   w_sh, w_trial;
        logic            w_ge;
        logic [RB+1:0]   r_rem;
        logic [RB-1:0]   r_root;
        logic [2*RB-1:0] r_rad;
        logic [SW-1:0]   r_side;
        logic            r_vld;

        assign w_sh    = {a_rem[k][RB-1:0], a_rad[k][2*RB-1 -: 2]};
        assign w_trial = {a_root[k], 2'b01};
        assign w_ge    = (w_sh >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= a_vld[k];
            end
            if (i_en) begin
                r_rem  <= w_ge ? (w_sh - w_trial) : w_sh;
                r_root <= {a_root[k][RB-2:0], w_ge};
                r_rad  <= {a_rad[k][2*RB-3:0], 2'b00};
                r_side <= a_side[k];
            end
        end

        assign a_rem[k+1]  = r_rem;
        assign a_root[k+1] = r_root;
        assign a_rad[k+1]  = r_rad;
        assign a_side[k+1] = r_side;
        assign a_vld[k+1]  = r_vld;
    end

    assign o_valid = a_vld[RB];
    assign o_root  = a_root[RB];
    assign o_side  = a_side[RB];

endmodule

`default_nettype wire

FILE: rtl/core/qrs_div.sv
`default_nettype none

module qrs_div #(
    parameter int NB = 50,
    parameter int DB = 33,
    parameter int SW = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [NB-1:0] i_num,
    input  wire logic [DB-1:0] i_den,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic [NB-1:0]      o_quo,
    output logic [SW-1:0]      o_side
);

    logic [DB-1:0] a_rem [NB+1];
    logic [NB-1:0] a_quo [NB+1];
    logic [NB-1:0] a_num [NB+1];
    logic [DB-1:0] a_den [NB+1];
    logic [SW-1:0] a_side [NB+1];
    logic          a_vld [NB+1];

    assign a_rem[0]  = '0;
    assign a_quo[0]  = '0;
    assign a_num[0]  = i_num;
    assign a_den[0]  = i_den;
    assign a_side[0] = i_side;
    assign a_vld[0]  = i_valid;

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < NB; k++) begin : g_stage
        logic [DB:0]   w_sh, w_diff;
        logic          w_ge;
        logic [DB-1:0] r_rem;
        logic [NB-1:0] r_quo;
        logic [NB-1:0] r_num;
        logic [DB-1:0] r_den;
        logic [SW-1:0] r_side;
        logic          r_vld;

        assign w_sh   = {a_rem[k], a_num[k][NB-1]};
        assign w_ge   = (w_sh >= {1'b0, a_den[k]});
        assign w_diff = w_sh - {1'b0, a_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= a_vld[k];
            end
            if (i_en) begin
                r_rem  <= w_ge ? w_diff[DB-1:0] : w_sh[DB-1:0];
                r_quo  <= {a_quo[k][NB-2:0], w_ge};
                r_num  <= {a_num[k][NB-2:0], 1'b0};
                r_den  <= a_den[k];
                r_side <= a_side[k];
            end
        end

        assign a_rem[k+1]  = r_rem;
        assign a_quo[k+1]  = r_quo;
        assign a_num[k+1]  = r_num;
        assign a_den[k+1]  = r_den;
        assign a_side[k+1] = r_side;
        assign a_vld[k+1]  = r_vld;
    end

    assign o_valid = a_vld[NB];
    assign o_quo   = a_quo[NB];
    assign o_side  = a_side[NB];

endmodule

`default_nettype wire

FILE: rtl/core/qrs_back.sv
`default_nettype none

module qrs_back
    import qrs_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    output logic               o_pop,
    input  wire logic [7*W+4:0] i_data,
    qrs_rsp_if.source          o_rsp
);

    localparam int RB  = W + 1;
    localparam int SQW = 6 + 3*W;
    localparam int NB  = W + 2 + F;
    localparam int DB  = W + 1;

    logic en;

    t_cls           w_cls;
    logic           w_na, w_nb, w_nc;
    logic [W-1:0]   w_ma, w_mb, w_mc;
    logic [2*W-1:0] w_b2, w_ac;
    logic signed [2*W+2:0] w_b2e, w_ac4e, w_d;
    t_status        w_st0;

    logic              r_b0_v;
    logic [2*RB-1:0]   r_dmag;
    logic [SQW-1:0]    r_side0;

    logic           s_v;
    logic [RB-1:0]  s_root;
    logic [SQW-1:0] s_side;
    logic [1:0]     s_st;
    logic           s_a0, s_na, s_nb, s_nc;
    logic [W-1:0]   s_ma, s_mb, s_mc;

    logic signed [W+2:0] w_negb, w_rt, w_sp, w_sm, w_spa, w_sma;
    logic           w_neg_p, w_neg_m, w_neg_l;
    logic [NB-1:0]  w_num0, w_num1;
    logic [DB-1:0]  w_den0, w_den1;

    logic           q_v;
    logic [NB-1:0]  q_p, q_m;
    logic [3:0]     q_side0;
    logic [0:0]     q_side1;
    t_status        q_st;
    logic [W:0]     w_cp, w_cm;

    logic           r_ov;
    logic [1:0]     r_st;
    logic [W-1:0]   r_rp, r_rm;
    logic           r_sat;

    function automatic logic [W:0] clamp(input logic neg, input logic [NB-1:0] q);
        logic         big, exact;
        logic [W-1:0] neg_q;
        big   = |q[NB-1:W-1];
        exact = (q == (NB'(1) << (W-1)));
        neg_q = ~q[W-1:0] + W'(1);
        if (neg) begin
            clamp = (big && !exact) ? {2'b11, {(W-1){1'b0}}} : {1'b0, neg_q};
        end else begin
            clamp = big ? {2'b10, {(W-1){1'b1}}} : {1'b0, q[W-1:0]};
        end
    endfunction

    assign en    = !r_ov || o_rsp.ready;
    assign o_pop = en && !i_empty;

    // discriminant and classification
    assign {w_cls, w_na, w_nb, w_nc, w_ma, w_mb, w_mc, w_b2, w_ac} = i_data;
    assign w_b2e  = $signed({3'b000, w_b2});
    assign w_ac4e = $signed({1'b0, w_ac, 2'b00});
    assign w_d    = (w_na ^ w_nc) ? (w_b2e + w_ac4e) : (w_b2e - w_ac4e);

    always_comb begin
        if (w_cls.a_zero) begin
            w_st0 = w_cls.b_zero ? ST_INVALID : ST_ONE_ROOT;
        end else if (w_d[2*W+2]) begin
            w_st0 = ST_NO_ROOTS;
        end else if (w_d == '0) begin
            w_st0 = ST_ONE_ROOT;
        end else begin
            w_st0 = ST_TWO_ROOTS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0_v <= 1'b0;
        end else if (en) begin
            r_b0_v <= !i_empty;
        end
        if (en) begin
            r_dmag  <= w_d[2*W+2] ? '0 : w_d[2*W+1:0];
            r_side0 <= {w_st0, w_cls.a_zero, w_na, w_nb, w_nc, w_ma, w_mb, w_mc};
        end
    end

    qrs_isqrt #(.RB(RB), .SW(SQW)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b0_v),
        .i_rad   (r_dmag),
        .i_side  (r_side0),
        .o_valid (s_v),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    // numerators -b +/- sqrt(D), or -c for the linear case
    assign {s_st, s_a0, s_na, s_nb, s_nc, s_ma, s_mb, s_mc} = s_side;
    assign w_negb = s_nb ? $signed({3'b000, s_mb}) : -$signed({3'b000, s_mb});
    assign w_rt   = $signed({2'b00, s_root});
    assign w_sp   = w_negb + w_rt;
    assign w_sm   = w_negb - w_rt;
    assign w_spa  = w_sp[W+2] ? -w_sp : w_sp;
    assign w_sma  = w_sm[W+2] ? -w_sm : w_sm;
    assign w_neg_p = w_sp[W+2] ^ s_na;
    assign w_neg_m = w_sm[W+2] ^ s_na;
    assign w_neg_l = (s_mc != '0) && !(s_nc ^ s_nb);

    assign w_num0 = s_a0 ? (NB'({2'b00, s_mc}) << F) : (NB'(w_spa[W+1:0]) << F);
    assign w_den0 = s_a0 ? {1'b0, s_mb} : {s_ma, 1'b0};
    assign w_num1 = NB'(w_sma[W+1:0]) << F;
    assign w_den1 = {s_ma, 1'b0};

    qrs_div #(.NB(NB), .DB(DB), .SW(4)) u_div_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_v),
        .i_num   (w_num0),
        .i_den   (w_den0),
        .i_side  ({s_st, s_a0, s_a0 ? w_neg_l : w_neg_p}),
        .o_valid (q_v),
        .o_quo   (q_p),
        .o_side  (q_side0)
    );

    qrs_div #(.NB(NB), .DB(DB), .SW(1)) u_div_m (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_v),
        .i_num   (w_num1),
        .i_den   (w_den1),
        .i_side  (w_neg_m),
        .o_valid (),
        .o_quo   (q_m),
        .o_side  (q_side1)
    );

    assign q_st = t_status'(q_side0[3:2]);
    assign w_cp = clamp(q_side0[0], q_p);
    assign w_cm = clamp(q_side1[0], q_m);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= q_v;
        end
        if (en) begin
            r_st <= q_st;
            case (q_st)
                ST_TWO_ROOTS: begin
                    r_rp  <= w_cp[W-1:0];
                    r_rm  <= w_cm[W-1:0];
                    r_sat <= w_cp[W] | w_cm[W];
                end
                ST_ONE_ROOT: begin
                    r_rp  <= w_cp[W-1:0];
                    r_rm  <= w_cp[W-1:0];
                    r_sat <= w_cp[W];
                end
                default: begin
                    r_rp  <= '0;
                    r_rm  <= '0;
                    r_sat <= 1'b0;
                end
            endcase
        end
    end

    assign o_rsp.valid      = r_ov;
    assign o_rsp.status     = r_st;
    assign o_rsp.root_plus  = r_rp;
    assign o_rsp.root_minus = r_rm;
    assign o_rsp.saturated  = r_sat;

endmodule

`default_nettype wire
